FILE: rtl/nsl_pkg.sv
package nsl_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int T_FRAC_BITS_DEF  = 16;

  localparam int COORD_W = 24;
  localparam int ARC_W   = 24;
  localparam int DIR_W   = 16;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int CROSS_W = 25;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [IDX_W-1:0]           entry_index;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic [ARC_W-1:0]           start_arc;
    logic [ARC_W-1:0]           seg_len;
    logic signed [DIR_W-1:0]    seg_dir;
    logic signed [COORD_W-1:0]  robot_x;
    logic signed [COORD_W-1:0]  robot_y;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic [CNT_W-1:0]           nearest_id;
    logic [ARC_W-1:0]           along_dist;
    logic [ARC_W-1:0]           robot_arc;
    logic [CROSS_W-1:0]         cross_track;
    logic signed [DIR_W-1:0]    near_dir;
  } result_t;

  // one table entry as stored in the segment ram
  typedef struct packed {
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic [ARC_W-1:0]           start_arc;
    logic [ARC_W-1:0]           seg_len;
    logic signed [DIR_W-1:0]    seg_dir;
  } seg_t;

  // request as classified by the front
  typedef struct packed {
    logic     is_query;
    logic     idx_ok;
    in_item_t item;
  } front_req_t;

endpackage

FILE: rtl/nearest_segment_locator.sv
// channel  | direction | handshake          | payload
// request  | in        | push / full        | in_item_i   (in_item_t)
// result   | out       | empty / pop        | result_o    (result_t)
// config   | in        | cfg_we_i           | cfg_wdata_i (segments in use)
//
// a segment write is stored in the table as it leaves the queue head with the
// engine idle; a query scans its n segments one after another with a
// per-segment restoring divide, then runs the bit-serial square root (28 steps
// here); a zero-length segment is skipped before the divide.
// reset clears the request queue, the result slot and the segment count;
// table contents are undefined until written.
// a two-entry request queue takes new requests while the engine works or a
// result waits in the output register for pop.
module nearest_segment_locator
  import nsl_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item_i,
  output logic             empty,
  input  logic             pop,
  output result_t          result_o
);

  logic [CNT_W-1:0] seg_count_q;
  logic             req_valid, req_ack, res_valid;
  front_req_t       req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= '0;
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  nsl_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ack_i   (req_ack)
  );

  nsl_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .T_FRAC_BITS  (T_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_count_i (seg_count_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ack_o   (req_ack),
    .res_valid_o (res_valid),
    .res_o       (result_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

endmodule

FILE: rtl/nsl_ram.sv
module nsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nsl_front.sv
module nsl_front
  import nsl_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item_i,
  output logic       req_valid_o,
  output front_req_t req_o,
  input  logic       req_ack_i
);

  front_req_t  slot_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;
  front_req_t  cls;

  always_comb begin
    cls.item     = in_item_i;
    cls.is_query = (in_item_i.mode == MODE_QUERY);
    cls.idx_ok   = (int'(in_item_i.entry_index) < MAX_SEGMENTS);
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign do_pop      = req_valid_o && req_ack_i;
  assign req_o       = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = !wptr_q;
    end
    if (do_pop) begin
      rptr_d = !rptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/nsl_sqrt.sv
module nsl_sqrt #(
  parameter int XW = 56,
  parameter int RW = XW / 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [RW-1:0] root_o
);

  localparam int KW = $clog2(RW + 1);

  logic [XW-1:0] x_q, x_d;
  logic [RW+2:0] rem_q, rem_d;
  logic [RW-1:0] root_q, root_d;
  logic [KW-1:0] k_q, k_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [RW+2:0] shifted, trial;

  // two radicand bits per step, one root bit out
  assign shifted = {rem_q[RW:0], x_q[XW-1:XW-2]};
  assign trial   = {1'b0, root_q, 2'b01};

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = x_q << 2;
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[RW-2:0], 1'b0};
      end
      k_d = k_q + KW'(1);
      if (k_q == KW'(RW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/nsl_back.sv
module nsl_back
  import nsl_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] cfg_count_i,
  input  logic             req_valid_i,
  input  front_req_t       req_i,
  output logic             req_ack_o,
  output logic             res_valid_o,
  output result_t          res_o,
  input  logic             res_pop_i
);

  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int TW   = T_FRAC_BITS + 1;
  localparam int KW   = $clog2(T_FRAC_BITS);
  localparam int DW   = COORD_W + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = PW;
  localparam int QW   = DW + TW + 1;
  localparam int VW   = DW + 2;
  localparam int SW   = 2 * VW;
  localparam int XW   = ((SW + 2) / 2) * 2;
  localparam int RTW  = XW / 2;
  localparam int AMW  = TW + ARC_W;
  localparam int SEGW = $bits(seg_t);

  localparam logic [TW-1:0]        T_ONE   = TW'(1) << T_FRAC_BITS;
  localparam logic signed [QW-1:0] Q_HALF  = QW'(1) << (T_FRAC_BITS - 1);
  localparam logic [AMW-1:0]       A_HALF  = AMW'(1) << (T_FRAC_BITS - 1);
  localparam logic [ARC_W-1:0]     ARC_MAX = '1;
  localparam logic [CROSS_W-1:0]   CT_MAX  = '1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_SUB   = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_ADD   = 4'd4;
  localparam logic [3:0] ST_CLS   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_PROJ  = 4'd7;
  localparam logic [3:0] ST_OFS   = 4'd8;
  localparam logic [3:0] ST_SQ    = 4'd9;
  localparam logic [3:0] ST_CMP   = 4'd10;
  localparam logic [3:0] ST_ALONG = 4'd11;
  localparam logic [3:0] ST_SQRT  = 4'd12;

  logic [3:0] state_q, state_d;

  // scan control
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic          found_q, found_d;
  logic signed [COORD_W-1:0] rx_q, ry_q;

  // per segment datapath
  logic signed [DW-1:0]   dx_q, dy_q, ex_q, ey_q;
  logic signed [PW-1:0]   p1_q, p2_q, p3_q, p4_q;
  logic [LW-1:0]          len2_q;
  logic signed [PW:0]     num_q;
  logic [LW:0]            r_q, r_d, r2;
  logic [TW-1:0]          t_q, t_d;
  logic [KW-1:0]          k_q, k_d;
  logic signed [QW-1:0]   q1_q, q2_q, rs1, rs2;
  logic signed [VW-1:0]   vx_q, vy_q;
  logic [SW-1:0]          s1_q, s2_q;
  logic [SW:0]            d2;
  logic [ARC_W-1:0]       sarc_q, len_q;
  logic signed [DIR_W-1:0] dir_q;

  // best so far
  logic [SW:0]             best_d2_q;
  logic [TW-1:0]           best_t_q;
  logic [CW-1:0]           best_i_q;
  logic [ARC_W-1:0]        best_sarc_q, best_len_q;
  logic signed [DIR_W-1:0] best_dir_q;
  logic [AMW-1:0]          along_prod_q;

  logic       res_valid_q, res_valid_d;
  result_t    res_q, res_d;

  logic       ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [SEGW-1:0] ram_wdata, ram_rdata;
  seg_t       seg_in, seg_rd;

  logic       sqrt_start, sqrt_busy, sqrt_done;
  logic [RTW-1:0] sqrt_root;
  logic       last_seg;
  logic [ARC_W:0] along_full, arc_full;

  always_comb begin
    seg_in.start_x   = req_i.item.start_x;
    seg_in.start_y   = req_i.item.start_y;
    seg_in.end_x     = req_i.item.end_x;
    seg_in.end_y     = req_i.item.end_y;
    seg_in.start_arc = req_i.item.start_arc;
    seg_in.seg_len   = req_i.item.seg_len;
    seg_in.seg_dir   = req_i.item.seg_dir;
  end

  assign ram_wdata = seg_in;
  assign ram_waddr = AW'(req_i.item.entry_index);
  assign ram_re    = (state_q == ST_RD);
  assign seg_rd    = seg_t'(ram_rdata);

  nsl_ram #(
    .WIDTH (SEGW),
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  nsl_sqrt #(
    .XW (XW),
    .RW (RTW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (XW'(best_d2_q)),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign last_seg = (idx_q == cnt_q - CW'(1));
  assign r2       = r_q << 1;
  // halves round toward plus infinity
  assign rs1      = (q1_q + Q_HALF) >>> T_FRAC_BITS;
  assign rs2      = (q2_q + Q_HALF) >>> T_FRAC_BITS;
  assign d2       = (SW+1)'(s1_q) + (SW+1)'(s2_q);
  assign along_full = (ARC_W+1)'((along_prod_q + A_HALF) >> T_FRAC_BITS);
  assign arc_full   = (ARC_W+1)'(best_sarc_q) +
                      ((along_full > (ARC_W+1)'(ARC_MAX)) ? (ARC_W+1)'(ARC_MAX) : along_full);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    r_d         = r_q;
    t_d         = t_q;
    k_d         = k_q;
    req_ack_o   = 1'b0;
    ram_we      = 1'b0;
    sqrt_start  = 1'b0;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_valid_q && res_pop_i) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (!req_i.is_query) begin
            req_ack_o = 1'b1;
            ram_we    = req_i.idx_ok;
          end else if (!res_valid_q) begin
            req_ack_o = 1'b1;
            found_d   = 1'b0;
            idx_d     = '0;
            if (int'(cfg_count_i) > MAX_SEGMENTS) begin
              cnt_d = CW'(MAX_SEGMENTS);
            end else begin
              cnt_d = CW'(cfg_count_i);
            end
            if (cfg_count_i == '0) begin
              state_d = ST_ALONG;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end
      ST_RD:   state_d = ST_SUB;
      ST_SUB:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_CLS;
      ST_CLS: begin
        if (len2_q == '0) begin
          // zero-length segment, skip it
          if (last_seg) begin
            state_d = ST_ALONG;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_RD;
          end
        end else if (num_q <= 0) begin
          t_d     = '0;
          state_d = ST_PROJ;
        end else if ($unsigned(num_q) >= (LW+1)'(len2_q)) begin
          t_d     = T_ONE;
          state_d = ST_PROJ;
        end else begin
          r_d     = $unsigned(num_q);
          t_d     = '0;
          k_d     = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (r2 >= (LW+1)'(len2_q)) begin
          r_d = r2 - (LW+1)'(len2_q);
          t_d = {t_q[TW-2:0], 1'b1};
        end else begin
          r_d = r2;
          t_d = {t_q[TW-2:0], 1'b0};
        end
        k_d = k_q + KW'(1);
        if (k_q == KW'(T_FRAC_BITS - 1)) begin
          state_d = ST_PROJ;
        end
      end
      ST_PROJ: state_d = ST_OFS;
      ST_OFS:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_CMP;
      ST_CMP: begin
        if (!found_q || d2 < best_d2_q) begin
          found_d = 1'b1;
        end
        if (last_seg) begin
          state_d = ST_ALONG;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_RD;
        end
      end
      ST_ALONG: begin
        if (found_q) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end else begin
          res_d       = '0;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          res_d.found      = 1'b1;
          res_d.nearest_id = CNT_W'(best_i_q + CW'(1));
          res_d.along_dist = (along_full > (ARC_W+1)'(ARC_MAX)) ? ARC_MAX
                                                              : ARC_W'(along_full);
          res_d.robot_arc  = (arc_full > (ARC_W+1)'(ARC_MAX)) ? ARC_MAX
                                                            : ARC_W'(arc_full);
          res_d.cross_track = (sqrt_root > RTW'(CT_MAX)) ? CT_MAX
                                                         : CROSS_W'(sqrt_root);
          res_d.near_dir   = best_dir_q;
          res_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    r_q   <= r_d;
    t_q   <= t_d;
    if (state_q == ST_IDLE && req_ack_o) begin
      rx_q <= req_i.item.robot_x;
      ry_q <= req_i.item.robot_y;
    end
    if (state_q == ST_SUB) begin
      dx_q   <= DW'(seg_rd.end_x) - DW'(seg_rd.start_x);
      dy_q   <= DW'(seg_rd.end_y) - DW'(seg_rd.start_y);
      ex_q   <= DW'(rx_q) - DW'(seg_rd.start_x);
      ey_q   <= DW'(ry_q) - DW'(seg_rd.start_y);
      sarc_q <= seg_rd.start_arc;
      len_q  <= seg_rd.seg_len;
      dir_q  <= seg_rd.seg_dir;
    end
    if (state_q == ST_MUL) begin
      p1_q <= dx_q * dx_q;
      p2_q <= dy_q * dy_q;
      p3_q <= ex_q * dx_q;
      p4_q <= ey_q * dy_q;
    end
    if (state_q == ST_ADD) begin
      len2_q <= $unsigned(p1_q) + $unsigned(p2_q);
      num_q  <= (PW+1)'(p3_q) + (PW+1)'(p4_q);
    end
    if (state_q == ST_PROJ) begin
      q1_q <= QW'(dx_q) * $signed({1'b0, t_q});
      q2_q <= QW'(dy_q) * $signed({1'b0, t_q});
    end
    if (state_q == ST_OFS) begin
      vx_q <= VW'(ex_q) - VW'(rs1);
      vy_q <= VW'(ey_q) - VW'(rs2);
    end
    if (state_q == ST_SQ) begin
      s1_q <= $unsigned(SW'(vx_q) * SW'(vx_q));
      s2_q <= $unsigned(SW'(vy_q) * SW'(vy_q));
    end
    if (state_q == ST_CMP && (!found_q || d2 < best_d2_q)) begin
      best_d2_q   <= d2;
      best_t_q    <= t_q;
      best_i_q    <= idx_q;
      best_sarc_q <= sarc_q;
      best_len_q  <= len_q;
      best_dir_q  <= dir_q;
    end
    if (state_q == ST_ALONG) begin
      along_prod_q <= AMW'(best_t_q) * AMW'(best_len_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP || state_q == ST_CLS) |-> (idx_q < cnt_q))
    else $error("scan index beyond segment count");

  a_sqrt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

  a_query_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_ack_o && req_i.is_query) |-> !res_valid_q)
    else $error("query taken while a result waits");

  a_found_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(res_valid_q) && res_q.found) |-> (res_q.nearest_id != '0))
    else $error("found result without segment id");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import nsl_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int FRAC = 16;
  localparam longint ARC_SAT = 64'd16777215;
  localparam longint CROSS_SAT = 64'd33554431;
  localparam int SETTLE_CYCLES = 3000;

  logic clk;
  logic rst_ni;
  logic cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic push;
  logic full;
  in_item_t in_item_i;
  logic empty;
  logic pop;
  result_t result_o;

  nearest_segment_locator uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  // local copy of the segment table and the count register
  longint tab_sx[TBL_DEPTH];
  longint tab_sy[TBL_DEPTH];
  longint tab_ex[TBL_DEPTH];
  longint tab_ey[TBL_DEPTH];
  longint tab_arc[TBL_DEPTH];
  longint tab_len[TBL_DEPTH];
  logic signed [DIR_W-1:0] tab_dir[TBL_DEPTH];
  int seg_count;

  result_t nearest_q[$];
  int errors;
  int burst_left;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor((v + half) / 2^FRAC)
  function automatic longint round_frac(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic result_t locate_nearest(longint rx, longint ry);
    result_t res;
    int n;
    bit hit;
    longint best_d2, best_t, dx, dy, len2, num, t, rem, vx, vy, d2, along, arc;
    int best_i;
    res = '0;
    hit = 0;
    best_d2 = 0;
    best_t = 0;
    best_i = 0;
    n = (seg_count > TBL_DEPTH) ? TBL_DEPTH : seg_count;
    for (int i = 0; i < n; i++) begin
      dx = tab_ex[i] - tab_sx[i];
      dy = tab_ey[i] - tab_sy[i];
      len2 = dx * dx + dy * dy;
      if (len2 == 0) continue;
      num = (rx - tab_sx[i]) * dx + (ry - tab_sy[i]) * dy;
      if (num <= 0) begin
        t = 0;
      end else if (num >= len2) begin
        t = 64'sd1 <<< FRAC;
      end else begin
        rem = num;
        t = 0;
        for (int k = 0; k < FRAC; k++) begin
          rem = rem <<< 1;
          t = t <<< 1;
          if (rem >= len2) begin
            rem = rem - len2;
            t = t | 1;
          end
        end
      end
      vx = (rx - tab_sx[i]) - round_frac(dx * t);
      vy = (ry - tab_sy[i]) - round_frac(dy * t);
      d2 = vx * vx + vy * vy;
      if (!hit || d2 < best_d2) begin
        hit = 1;
        best_d2 = d2;
        best_t = t;
        best_i = i;
      end
    end
    if (!hit) return res;
    along = (best_t * tab_len[best_i] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    arc = tab_arc[best_i] + along;
    if (along > ARC_SAT) along = ARC_SAT;
    if (arc > ARC_SAT) arc = ARC_SAT;
    res.found = 1'b1;
    res.nearest_id = CNT_W'(best_i + 1);
    res.along_dist = ARC_W'(along);
    res.robot_arc = ARC_W'(arc);
    d2 = longint'(int_sqrt(best_d2));
    res.cross_track = CROSS_W'((d2 > CROSS_SAT) ? CROSS_SAT : d2);
    res.near_dir = tab_dir[best_i];
    return res;
  endfunction

  task automatic apply_request(in_item_t it);
    int idx;
    if (it.mode == MODE_WRITE) begin
      idx = it.entry_index;
      tab_sx[idx] = it.start_x;
      tab_sy[idx] = it.start_y;
      tab_ex[idx] = it.end_x;
      tab_ey[idx] = it.end_y;
      tab_arc[idx] = it.start_arc;
      tab_len[idx] = it.seg_len;
      tab_dir[idx] = it.seg_dir;
    end else begin
      nearest_q.insert(nearest_q.size(), locate_nearest(it.robot_x, it.robot_y));
    end
  endtask

  task automatic send_request(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_item_i <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    apply_request(it);
  endtask

  // stop sending, drain all results, let trailing writes land in the table
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_count(int v);
    @(negedge clk);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CNT_W'(v);
    @(negedge clk);
    cfg_we_i <= 1'b0;
    seg_count = v & 'h7f;
  endtask

  function automatic logic [COORD_W-1:0] near_coord(int center);
    return COORD_W'(center + int'($urandom_range(0, 6000)) - 3000);
  endfunction

  function automatic in_item_t make_segment(int idx, int cx, int cy);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom});
    it.mode = MODE_WRITE;
    it.entry_index = IDX_W'(idx);
    if ($urandom_range(0, 3) != 0) begin
      it.start_x = near_coord(cx);
      it.start_y = near_coord(cy);
      it.end_x = near_coord(cx);
      it.end_y = near_coord(cy);
      it.start_arc = ARC_W'($urandom_range(0, 100000));
      it.seg_len = ARC_W'($urandom_range(0, 9000));
    end
    if ($urandom_range(0, 11) == 0) begin
      it.end_x = it.start_x;
      it.end_y = it.start_y;
    end
    return it;
  endfunction

  function automatic in_item_t make_query(int cx, int cy);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom});
    it.mode = MODE_QUERY;
    if ($urandom_range(0, 3) != 0) begin
      it.robot_x = near_coord(cx);
      it.robot_y = near_coord(cy);
    end
    return it;
  endfunction

  function automatic in_item_t seg_item(int idx, int sx, int sy, int ex, int ey,
                                        int arc, int len, int dir);
    in_item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.entry_index = IDX_W'(idx);
    it.start_x = COORD_W'(sx);
    it.start_y = COORD_W'(sy);
    it.end_x = COORD_W'(ex);
    it.end_y = COORD_W'(ey);
    it.start_arc = ARC_W'(arc);
    it.seg_len = ARC_W'(len);
    it.seg_dir = DIR_W'(dir);
    return it;
  endfunction

  function automatic in_item_t query_item(int rx, int ry);
    in_item_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.robot_x = COORD_W'(rx);
    it.robot_y = COORD_W'(ry);
    return it;
  endfunction

  task automatic test_empty_table();
    send_request(query_item(1234, -5678));
    wait_idle();
  endtask

  task automatic test_extremes();
    send_request(seg_item(0, -8388608, -8388608, 8388607, 8388607, 16777215, 16777215,
                          -32768));
    send_request(seg_item(1, 0, 0, 0, 0, 77, 88, 32767));
    // same line as entry 0, so every query ties and entry 0 must win
    send_request(seg_item(2, -8388608, -8388608, 8388607, 8388607, 5, 100, 1000));
    wait_idle();
    set_count(3);
    send_request(query_item(8388607, -8388608));
    send_request(query_item(-8388608, -8388608));
    send_request(query_item(8388607, 8388607));
    send_request(query_item(-8388608, 8388607));
    send_request(query_item(0, 0));
    wait_idle();
    set_count(2);
    send_request(seg_item(0, 10, 20, 10, 20, 1, 2, 3));
    send_request(query_item(-8388608, 8388607));
    send_request(seg_item(0, -100, 0, 100, 0, 16777000, 200, 0));
    send_request(query_item(500, 300));
    send_request(query_item(0, -300));
    wait_idle();
  endtask

  task automatic test_load_route();
    for (int i = 0; i < TBL_DEPTH; i++) send_request(make_segment(i, 0, 0));
    wait_idle();
  endtask

  task automatic test_count_limits();
    set_count(64);
    repeat (6) send_request(make_query(0, 0));
    wait_idle();
    // counts above the table size search the whole table
    set_count(127);
    repeat (6) send_request(make_query(0, 0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int cnt;
    int cx;
    int cy;
    for (int ph = 0; ph < 18; ph++) begin
      if (ph == 7) cnt = 64;
      else if (ph == 13) cnt = 100;
      else if (ph == 3) cnt = 0;
      else cnt = $urandom_range(1, 10);
      set_count(cnt);
      cx = int'($urandom_range(0, 16000000)) - 8000000;
      cy = int'($urandom_range(0, 16000000)) - 8000000;
      for (int i = 0; i < ((cnt >= 64) ? 30 : 110); i++) begin
        if ($urandom_range(0, 1) == 0)
          send_request(make_segment($urandom_range(0, TBL_DEPTH - 1), cx, cy));
        else
          send_request(make_query(cx, cy));
      end
      wait_idle();
    end
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    seg_count = 0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    push = 1'b0;
    in_item_i = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tab_sx[i] = 0;
      tab_sy[i] = 0;
      tab_ex[i] = 0;
      tab_ey[i] = 0;
      tab_arc[i] = 0;
      tab_len[i] = 0;
      tab_dir[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    test_empty_table();
    test_extremes();
    test_load_route();
    test_count_limits();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver stall level is redrawn periodically, zero included
  initial begin
    stall_pct = 0;
    forever begin
      repeat (400) @(posedge clk);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
  end

  always @(negedge clk) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (nearest_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = nearest_q.pop_front();
        if (result_o.found !== want.found) begin
          $error("found exp %0d got %0d", want.found, result_o.found);
          errors++;
        end
        if (result_o.nearest_id !== want.nearest_id) begin
          $error("nearest_id exp %0d got %0d", want.nearest_id, result_o.nearest_id);
          errors++;
        end
        if (result_o.along_dist !== want.along_dist) begin
          $error("along_dist exp %0d got %0d", want.along_dist, result_o.along_dist);
          errors++;
        end
        if (result_o.robot_arc !== want.robot_arc) begin
          $error("robot_arc exp %0d got %0d", want.robot_arc, result_o.robot_arc);
          errors++;
        end
        if (result_o.cross_track !== want.cross_track) begin
          $error("cross_track exp %0d got %0d", want.cross_track, result_o.cross_track);
          errors++;
        end
        if (result_o.near_dir !== want.near_dir) begin
          $error("near_dir exp %0d got %0d", want.near_dir, result_o.near_dir);
          errors++;
        end
      end
    end
  end

endmodule
